### sv/ap_pkg.sv
// ---------------------------------------------------------------------------
// ap_pkg: shared constants, types and helpers
// Widths, register indexes, pipeline cell payload and saturation helper for
// the affinity propagation block.
// ---------------------------------------------------------------------------
package ap_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CELLS      = MAX_POINTS * MAX_POINTS;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int LOAD_W     = ADDR_W + 1;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CHAIN_LEN  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_N_POINTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STABLE    = 2'd3;

   // payload carried by one cell of the element pipeline
   typedef struct packed {
      logic                     vld;
      logic [ADDR_W-1:0]        addr;
      logic [IDX_W-1:0]         idx;
      logic                     diag;
      logic signed [63:0]       a;
      logic signed [63:0]       b;
   } cell_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

### sv/ap_req_if.sv
// ---------------------------------------------------------------------------
// ap_req_if: similarity word channel
// Valid/ready channel carrying one signed Q16.16 matrix entry.
// ---------------------------------------------------------------------------
interface ap_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] similarity;

   modport source (output valid, output similarity, input ready);
   modport sink   (input valid, input similarity, output ready);
endinterface

### sv/ap_rsp_if.sv
// ---------------------------------------------------------------------------
// ap_rsp_if: cluster assignment channel
// Valid/ready channel carrying one per-point assignment.
// ---------------------------------------------------------------------------
interface ap_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  point_index;
   logic [5:0]  exemplar_index;
   logic        is_exemplar;
   logic [15:0] rounds_run;
   logic        converged;
   logic        last;

   modport source (output valid, output point_index, output exemplar_index,
                   output is_exemplar, output rounds_run, output converged,
                   output last, input ready);
   modport sink   (input valid, input point_index, input exemplar_index,
                   input is_exemplar, input rounds_run, input converged,
                   input last, output ready);
endinterface

### sv/ap_ram.sv
// ---------------------------------------------------------------------------
// ap_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ap_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/ap_cell.sv
// ---------------------------------------------------------------------------
// ap_cell: one cell of the element chain
// Holds one element in flight and hands it to the next cell every cycle.
// ---------------------------------------------------------------------------
module ap_cell (
   input  logic             clock,
   input  logic             reset,
   input  ap_pkg::cell_type d,
   output ap_pkg::cell_type q
);
   import ap_pkg::*;

   cell_type q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.vld <= 1'b0;
      end else begin
         q_ff.vld <= d.vld;
      end
      q_ff.addr <= d.addr;
      q_ff.idx  <= d.idx;
      q_ff.diag <= d.diag;
      q_ff.a    <= d.a;
      q_ff.b    <= d.b;
   end

   assign q = q_ff;
endmodule

### sv/affinity_propagation_clustering.sv
// ---------------------------------------------------------------------------
// affinity_propagation_clustering: damped affinity propagation engine
// Loads an n-by-n Q16.16 similarity matrix, iterates message passing and
// emits one exemplar assignment per point.
// ---------------------------------------------------------------------------
// The matrix is taken one word per cycle, row-major, while req_chan.ready is
// high. After the last word the block drops ready and runs rounds of message
// passing; each round streams the matrix four times through a three-cell
// element chain (row top-two search, responsibility update, column positive
// sum, availability update), one element per cycle per pass, with a drain of
// the chain after each pass. The damping multiply sits in the chain, so the
// single memory read port per store sets the element rate. After the last
// round each point gets an argmax scan followed by the result transfer;
// ready returns after the last result.
// No clearing pass is needed: the first round treats old messages as zero.
module affinity_propagation_clustering (
   input  logic                            clock,
   input  logic                            reset,
   ap_req_if.sink                          req_chan,
   ap_rsp_if.source                        rsp_chan,
   input  logic                            csr_we,
   input  logic [ap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ap_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ap_pkg::*;

   localparam logic [3:0] ST_LOAD = 4'd0;
   localparam logic [3:0] ST_R1   = 4'd1;
   localparam logic [3:0] ST_R2   = 4'd2;
   localparam logic [3:0] ST_C1   = 4'd3;
   localparam logic [3:0] ST_C2   = 4'd4;
   localparam logic [3:0] ST_RND  = 4'd5;
   localparam logic [3:0] ST_SCAN = 4'd6;
   localparam logic [3:0] ST_EMIT = 4'd7;

   localparam logic signed [33:0] NEG_INF = {1'b1, 33'd0};

   // configuration
   logic [6:0]  n_points_ff;
   logic [15:0] damping_ff, max_iter_ff, stable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_points_ff <= 7'd64;
         damping_ff  <= 16'd32768;
         max_iter_ff <= 16'd200;
         stable_ff   <= 16'd15;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_N_POINTS: n_points_ff <= csr_wdata[6:0];
            REG_DAMPING:  damping_ff  <= csr_wdata;
            REG_MAX_ITER: max_iter_ff <= csr_wdata;
            REG_STABLE:   stable_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0]  n_eff;
   logic [LOAD_W-1:0] nn;
   logic [15:0]       maxr, need;

   always_comb begin
      if (n_points_ff < 7'd2) n_eff = CNT_W'(2);
      else if (n_points_ff > 7'(MAX_POINTS)) n_eff = CNT_W'(MAX_POINTS);
      else n_eff = n_points_ff[CNT_W-1:0];
      nn   = LOAD_W'(n_eff * n_eff);
      maxr = (max_iter_ff == 16'd0) ? 16'd1 : max_iter_ff;
      need = (stable_ff == 16'd0) ? 16'd1 : stable_ff;
   end

   // control state
   logic [3:0]        state_ff;
   logic [LOAD_W-1:0] load_ff;
   logic [IDX_W-1:0]  row_ff;
   logic [CNT_W-1:0]  j_ff;
   logic              first_ff;
   logic [MAX_POINTS-1:0] flags_ff, exem_ff;
   logic [15:0]       stable_cnt_ff, round_ff;
   logic              conv_ff;

   // accumulators
   logic signed [33:0] m1_ff, m2_ff, bv_ff;
   logic [IDX_W-1:0]   at1_ff, best_ff;
   logic signed [37:0] pos_ff;
   logic signed [31:0] rkk_ff;

   // response register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_point_ff, rsp_exem_ff;
   logic              rsp_isex_ff, rsp_conv_ff, rsp_last_ff;
   logic [15:0]       rsp_rounds_ff;

   // element chain
   cell_type c_d [CHAIN_LEN];
   cell_type c_q [CHAIN_LEN];

   for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
      ap_cell u_cell (.clock(clock), .reset(reset), .d(c_d[g]), .q(c_q[g]));
   end

   logic in_pass, issue, drained, col_pass;
   logic [ADDR_W-1:0] rd_addr;
   logic [2*CNT_W-1:0] row_prod, col_prod;

   assign in_pass  = (state_ff == ST_R1) || (state_ff == ST_R2) || (state_ff == ST_C1) ||
                     (state_ff == ST_C2) || (state_ff == ST_SCAN);
   assign issue    = in_pass && (j_ff < n_eff);
   assign col_pass = (state_ff == ST_C1) || (state_ff == ST_C2);
   assign row_prod = {{(CNT_W-IDX_W){1'b0}}, row_ff} * n_eff + {{CNT_W{1'b0}}, j_ff};
   assign col_prod = j_ff * n_eff + {{(CNT_W+1){1'b0}}, row_ff};
   assign rd_addr  = col_pass ? col_prod[ADDR_W-1:0] : row_prod[ADDR_W-1:0];
   assign drained  = !issue && !c_q[0].vld && !c_q[1].vld && !c_q[2].vld;

   // memories
   logic [WORD_W-1:0] sim_q, resp_q, avail_q, wres;
   logic              sim_we, resp_we, avail_we;
   logic [ADDR_W-1:0] sim_waddr;

   assign sim_we    = (state_ff == ST_LOAD) && req_chan.valid && (load_ff < LOAD_W'(CELLS));
   assign sim_waddr = load_ff[ADDR_W-1:0];
   assign resp_we   = c_q[2].vld && (state_ff == ST_R2);
   assign avail_we  = c_q[2].vld && (state_ff == ST_C2);

   ap_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_sim (
      .clock(clock), .we(sim_we), .waddr(sim_waddr), .wdata(req_chan.similarity),
      .raddr(rd_addr), .rdata(sim_q));
   ap_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_resp (
      .clock(clock), .we(resp_we), .waddr(c_q[2].addr), .wdata(wres),
      .raddr(rd_addr), .rdata(resp_q));
   ap_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_avail (
      .clock(clock), .we(avail_we), .waddr(c_q[2].addr), .wdata(wres),
      .raddr(rd_addr), .rdata(avail_q));

   // first cell: element issue
   always_comb begin
      c_d[0].vld  = issue;
      c_d[0].addr = rd_addr;
      c_d[0].idx  = j_ff[IDX_W-1:0];
      c_d[0].diag = (j_ff[IDX_W-1:0] == row_ff);
      c_d[0].a    = '0;
      c_d[0].b    = '0;
   end

   // second cell: fresh message and old value
   logic signed [63:0] s64, r_old, a_old, r_new, a_new, msel, rpos, c2f;

   always_comb begin
      s64   = 64'(signed'(sim_q));
      r_new = 64'(signed'(resp_q));
      a_new = 64'(signed'(avail_q));
      r_old = (first_ff && state_ff == ST_R2) ? 64'sd0 : r_new;
      a_old = (first_ff && state_ff == ST_C2) ? 64'sd0 : a_new;
      msel  = (c_q[0].idx == at1_ff) ? 64'(m2_ff) : 64'(m1_ff);
      rpos  = (r_new > 0) ? r_new : 64'sd0;
      c2f   = 64'(rkk_ff) + 64'(pos_ff) - rpos;
      if (c2f > 0) c2f = 64'sd0;
      if (c_q[0].diag) c2f = 64'(pos_ff);
      c_d[1]     = c_q[0];
      c_d[1].vld = c_q[0].vld && ((state_ff == ST_R2) || (state_ff == ST_C2));
      if (state_ff == ST_R2) begin
         c_d[1].a = r_old;
         c_d[1].b = 64'(sat32(s64 - msel));
      end else begin
         c_d[1].a = a_old;
         c_d[1].b = 64'(sat32(c2f));
      end
   end

   // third cell: damping products
   logic signed [48:0] p1;
   logic signed [49:0] p2;
   logic [16:0]        inv_lam;

   always_comb begin
      inv_lam    = 17'(17'd65536 - {1'b0, damping_ff});
      p1         = $signed({1'b0, damping_ff}) * $signed(c_q[1].a[31:0]);
      p2         = $signed({1'b0, inv_lam}) * $signed(c_q[1].b[31:0]);
      c_d[2]     = c_q[1];
      c_d[2].a   = {{15{p1[48]}}, p1};
      c_d[2].b   = {{14{p2[49]}}, p2};
   end

   // write-back: round half up, saturate
   logic signed [63:0] dsum;
   logic signed [33:0] diag_sum;

   always_comb begin
      dsum     = (c_q[2].a + c_q[2].b + 64'sd32768) >>> 16;
      wres     = sat32(dsum);
      diag_sum = 34'(rkk_ff) + 34'(signed'(wres));
   end

   // per-element values on the first cell
   logic signed [33:0] v_r1, v_sc;
   assign v_r1 = 34'(signed'(first_ff ? 32'sd0 : signed'(avail_q))) + 34'(signed'(sim_q));
   assign v_sc = 34'(signed'(resp_q)) + 34'(signed'(avail_q));

   // round-end bookkeeping
   logic [15:0] stable_nx, round_nx;
   always_comb begin
      if (flags_ff == '0) stable_nx = 16'd0;
      else if (flags_ff == exem_ff) stable_nx = (stable_cnt_ff == 16'hffff) ?
                                                  stable_cnt_ff : stable_cnt_ff + 16'd1;
      else stable_nx = 16'd1;
      round_nx = round_ff + 16'd1;
   end

   logic last_row;
   assign last_row = ({1'b0, row_ff} == n_eff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_ff       <= '0;
         row_ff        <= '0;
         j_ff          <= '0;
         first_ff      <= 1'b0;
         flags_ff      <= '0;
         exem_ff       <= '0;
         stable_cnt_ff <= '0;
         round_ff      <= '0;
         conv_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (issue) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (avail_we && c_q[2].diag) begin
            flags_ff[row_ff] <= (diag_sum > 0);
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_chan.valid) begin
                  // a smaller size written during the load starts the run at once
                  if (load_ff + LOAD_W'(1) >= nn) begin
                     load_ff       <= '0;
                     state_ff      <= ST_R1;
                     row_ff        <= '0;
                     j_ff          <= '0;
                     first_ff      <= 1'b1;
                     flags_ff      <= '0;
                     exem_ff       <= '0;
                     stable_cnt_ff <= '0;
                     round_ff      <= '0;
                     conv_ff       <= 1'b0;
                  end else begin
                     load_ff <= load_ff + LOAD_W'(1);
                  end
               end
            end
            ST_R1: begin
               if (drained) begin
                  state_ff <= ST_R2;
                  j_ff     <= '0;
               end
            end
            ST_R2: begin
               if (drained) begin
                  j_ff <= '0;
                  if (last_row) begin
                     state_ff <= ST_C1;
                     row_ff   <= '0;
                  end else begin
                     state_ff <= ST_R1;
                     row_ff   <= row_ff + IDX_W'(1);
                  end
               end
            end
            ST_C1: begin
               if (drained) begin
                  state_ff <= ST_C2;
                  j_ff     <= '0;
               end
            end
            ST_C2: begin
               if (drained) begin
                  j_ff <= '0;
                  if (last_row) begin
                     state_ff <= ST_RND;
                  end else begin
                     state_ff <= ST_C1;
                     row_ff   <= row_ff + IDX_W'(1);
                  end
               end
            end
            ST_RND: begin
               stable_cnt_ff <= stable_nx;
               exem_ff       <= flags_ff;
               round_ff      <= round_nx;
               first_ff      <= 1'b0;
               row_ff        <= '0;
               j_ff          <= '0;
               if (stable_nx >= need) begin
                  conv_ff  <= 1'b1;
                  state_ff <= ST_SCAN;
               end else if (round_nx < maxr) begin
                  state_ff <= ST_R1;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (drained) begin
                  state_ff      <= ST_EMIT;
                  rsp_valid_ff  <= 1'b1;
                  rsp_point_ff  <= row_ff;
                  rsp_exem_ff   <= exem_ff[row_ff] ? row_ff : best_ff;
                  rsp_isex_ff   <= exem_ff[row_ff];
                  rsp_rounds_ff <= round_ff;
                  rsp_conv_ff   <= conv_ff;
                  rsp_last_ff   <= last_row;
               end
            end
            ST_EMIT: begin
               if (rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
                  j_ff         <= '0;
                  if (last_row) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_SCAN;
                     row_ff   <= row_ff + IDX_W'(1);
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   // accumulators fed from the first cell
   always_ff @(posedge clock) begin
      // clear the top-two search on the first cycle of each row pass
      if (state_ff == ST_R1 && j_ff == '0 && !c_q[0].vld) begin
         m1_ff <= NEG_INF;
         m2_ff <= NEG_INF;
      end else if (state_ff == ST_R1 && c_q[0].vld) begin
         if (v_r1 > m1_ff) begin
            m2_ff  <= m1_ff;
            m1_ff  <= v_r1;
            at1_ff <= c_q[0].idx;
         end else if (v_r1 > m2_ff) begin
            m2_ff <= v_r1;
         end
      end
      // clear the positive sum on the first cycle of each column pass
      if (state_ff == ST_C1 && j_ff == '0 && !c_q[0].vld) begin
         pos_ff <= '0;
      end else if (state_ff == ST_C1 && c_q[0].vld) begin
         if (c_q[0].diag) rkk_ff <= signed'(resp_q);
         else if (signed'(resp_q) > 32'sd0) pos_ff <= pos_ff + 38'(signed'(resp_q));
      end
      if (state_ff != ST_SCAN) begin
         bv_ff <= NEG_INF;
      end else if (c_q[0].vld && v_sc >= bv_ff) begin
         bv_ff   <= v_sc;
         best_ff <= c_q[0].idx;
      end
   end

   assign req_chan.ready          = (state_ff == ST_LOAD);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.point_index    = rsp_point_ff;
   assign rsp_chan.exemplar_index = rsp_exem_ff;
   assign rsp_chan.is_exemplar    = rsp_isex_ff;
   assign rsp_chan.rounds_run     = rsp_rounds_ff;
   assign rsp_chan.converged      = rsp_conv_ff;
   assign rsp_chan.last           = rsp_last_ff;
endmodule

### sv/ap_checker.sv
// ---------------------------------------------------------------------------
// ap_checker: port-level checks for the clustering block
// Watches the channel ports over time and flags inconsistent behavior.
// ---------------------------------------------------------------------------
module ap_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_point_index,
   input logic [5:0] rsp_exemplar_index,
   input logic       rsp_is_exemplar,
   input logic       rsp_last
);
   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_index)
         && $stable(rsp_exemplar_index))
      else $error("result changed while stalled");

   // no matrix words are taken while results are pending
   a_no_load_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("load open during result output");

   // an exemplar points at itself
   a_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_exemplar |-> rsp_exemplar_index == rsp_point_index)
      else $error("exemplar not assigned to itself");

   // output continues until the final point's transfer
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("load reopened before final result");
endmodule

bind affinity_propagation_clustering ap_checker u_ap_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_point_index(rsp_chan.point_index),
   .rsp_exemplar_index(rsp_chan.exemplar_index),
   .rsp_is_exemplar(rsp_chan.is_exemplar),
   .rsp_last(rsp_chan.last)
);
